/* rtl/rqfs_pkg.sv */
// ----------------------------------------------------------------------------
// rqfs_pkg: shared types and codes of the request queue
// Holds the request entry layout, the per-cycle cell control and the
// result status codes.
// ----------------------------------------------------------------------------
package rqfs_pkg;

  localparam int unsigned SizeW   = 31;
  localparam int unsigned HandleW = 16;
  localparam int unsigned NameW   = 32;
  localparam int unsigned OccW    = 5;
  localparam int unsigned CapW    = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLICY   = 1'b0,
    REG_CAPACITY = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SizeW-1:0]   size;
    logic [HandleW-1:0] handle;
    logic [NameW-1:0]   name;
  } entry_t;

  // Broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic   insert;
    logic   remove;
    logic   smallest_first;
    entry_t req;
  } cell_ctrl_t;

endpackage

/* rtl/rqfs_cell.sv */
// ----------------------------------------------------------------------------
// rqfs_cell: one slot of the request queue
// Holds one entry, decides locally whether the new request lands here, and
// shifts toward the tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
module rqfs_cell (
  input  logic                clk_i,
  input  rqfs_pkg::cell_ctrl_t ctrl_i,
  input  logic                held_i,
  input  logic                found_i,
  input  rqfs_pkg::entry_t    left_i,
  input  rqfs_pkg::entry_t    right_i,
  output logic                found_o,
  output rqfs_pkg::entry_t    entry_o
);
  import rqfs_pkg::*;

  entry_t entry_q, entry_d;
  logic   here;

  // The insert position is the first slot that is empty or, when serving
  // smallest first, holds a strictly larger size.
  assign here    = !held_i || (ctrl_i.smallest_first && (entry_q.size > ctrl_i.req.size));
  assign found_o = found_i || here;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (here) begin
        entry_d = ctrl_i.req;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/request_queue_fifo_or_smallest_first.sv */
// ----------------------------------------------------------------------------
// request_queue_fifo_or_smallest_first: bounded request queue
// Arrival-order or smallest-size-first queue built as a row of slot cells.
// ----------------------------------------------------------------------------
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, since every cell compares
// and shifts in the same cycle the item is taken.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset empties the queue, selects arrival order and a capacity of 16.
module request_queue_fifo_or_smallest_first #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [rqfs_pkg::SizeW-1:0]    file_size_i,
  input  logic [rqfs_pkg::HandleW-1:0]  conn_handle_i,
  input  logic [rqfs_pkg::NameW-1:0]    name_ref_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [rqfs_pkg::SizeW-1:0]    out_size_o,
  output logic [rqfs_pkg::HandleW-1:0]  out_handle_o,
  output logic [rqfs_pkg::NameW-1:0]    out_name_o,
  output logic [rqfs_pkg::OccW-1:0]     occupancy_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rqfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rqfs_pkg::CfgW-1:0]     cfg_data_i
);
  import rqfs_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned WideW = (CmpW > OccW) ? CmpW : OccW;

  logic            policy_q;
  logic [CapW-1:0] capacity_q;
  logic [CntW-1:0] count_q, count_d;

  logic            accept;
  logic [CmpW-1:0] limit;
  logic [CmpW-1:0] count_ext;
  logic            full;
  logic            empty;
  cell_ctrl_t      ctrl;
  entry_t          req;

  entry_t          cell_entry [QUEUE_DEPTH];
  logic            found      [QUEUE_DEPTH+1];

  logic [1:0]       status_d;
  entry_t           head_d;
  logic [WideW-1:0] occ_wide;

  status_e          status_q;
  entry_t           head_q;
  logic [OccW-1:0]  occ_q;
  logic             valid_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= 1'b0;
      capacity_q <= CapW'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_POLICY:   policy_q   <= cfg_data_i[0];
        REG_CAPACITY: capacity_q <= cfg_data_i[CapW-1:0];
        default:      ;
      endcase
    end
  end

  assign count_ext = CmpW'(count_q);
  assign limit     = (CmpW'(capacity_q) > CmpW'(QUEUE_DEPTH)) ? CmpW'(QUEUE_DEPTH)
                                                              : CmpW'(capacity_q);
  assign full      = count_ext >= limit;
  assign empty     = (count_q == '0);

  assign req.size   = file_size_i;
  assign req.handle = conn_handle_i;
  assign req.name   = name_ref_i;

  assign ctrl.insert         = accept && (cmd_e'(command_i) == CMD_INSERT) && !full;
  assign ctrl.remove         = accept && (cmd_e'(command_i) == CMD_REMOVE) && !empty;
  assign ctrl.smallest_first = policy_q;
  assign ctrl.req            = req;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = req;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = req;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end

    rqfs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .held_i  (count_q > CntW'(i)),
      .found_i (found[i]),
      .left_i  (left_e),
      .right_i (right_e),
      .found_o (found[i+1]),
      .entry_o (cell_entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    head_d   = '0;
    if (cmd_e'(command_i) == CMD_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d = count_q - CntW'(1);
        head_d  = cell_entry[0];
      end
    end
  end

  assign occ_wide = WideW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_e'(status_d);
      head_q   <= head_d;
      occ_q    <= occ_wide[OccW-1:0];
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign out_size_o     = head_q.size;
  assign out_handle_o   = head_q.handle;
  assign out_name_o     = head_q.name;
  assign occupancy_o    = occ_q;

  // Every accepted item yields one result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted item produced no result");

  // The held count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(QUEUE_DEPTH))
    else $error("held count beyond queue depth");

  // An insert at the limit reports full and leaves the count alone.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_e'(command_i) == CMD_INSERT) && full)
      |=> (status_o == ST_FULL) && $stable(count_q))
    else $error("insert into full queue not dropped");

  // A remove on an empty queue reports empty and returns no entry.
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_e'(command_i) == CMD_REMOVE) && empty)
      |=> (status_o == ST_EMPTY) && (out_size_o == '0) && (count_q == '0))
    else $error("remove on empty queue misreported");

endmodule

/* test/tb_request_queue_fifo_or_smallest_first.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_request_queue_fifo_or_smallest_first: self-checking bench of the queue
// A shadow copy of the queue follows every accepted item and register write.
// It predicts each outcome, which is then compared with the strobed result.
// The stimulus starts with a directed sequence. Random phases follow, each
// with its own policy and capacity.
// ----------------------------------------------------------------------------
module tb_request_queue_fifo_or_smallest_first;
  import rqfs_pkg::*;

  localparam int unsigned QueueDepth    = 16;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned ItemsPerPhase = 102;
  localparam logic [SizeW-1:0] SizeMax  = '1;

  localparam bit          PhasePolicy[NumPhases]    = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 1, 0, 1};
  localparam int unsigned PhaseCapacity[NumPhases]  = '{16, 16, 1, 31, 0, 17, 5, 16, 2, 16, 8, 31};
  localparam int unsigned PhaseInsertPct[NumPhases] = '{60, 60, 50, 70, 50, 40, 55, 75, 50, 35,
                                                        60, 50};

  typedef struct {
    status_e            status;
    logic [SizeW-1:0]   size;
    logic [HandleW-1:0] handle;
    logic [NameW-1:0]   name;
    logic [OccW-1:0]    occ;
  } outcome_t;

  // Shadow of the queue contents and registers, plus the outcomes still due.
  class queue_shadow;
    bit             smallest_first;
    logic [CapW-1:0] capacity;
    entry_t         shadow_slots[$];
    outcome_t       outcomes_due[$];
    int unsigned    errors;

    function new();
      smallest_first = 1'b0;
      capacity       = 5'd16;
      errors         = 0;
    endfunction

    function void note_reg_write(cfg_reg_e idx, logic [CfgW-1:0] data);
      if (idx == REG_POLICY) begin
        smallest_first = data[0];
      end else begin
        capacity = data;
      end
    endfunction

    function void note_request(cmd_e cmd, entry_t req);
      outcome_t    res;
      int unsigned limit;
      int unsigned pos;
      res.status = ST_DONE;
      res.size   = '0;
      res.handle = '0;
      res.name   = '0;
      limit = (32'(capacity) > QueueDepth) ? QueueDepth : 32'(capacity);
      if (cmd == CMD_INSERT) begin
        if (shadow_slots.size() >= limit) begin
          res.status = ST_FULL;
        end else begin
          pos = shadow_slots.size();
          // Smallest-first goes in front of the first strictly larger entry.
          if (smallest_first) begin
            for (int i = 0; i < shadow_slots.size(); i++) begin
              if (shadow_slots[i].size > req.size) begin
                pos = i;
                break;
              end
            end
          end
          shadow_slots.insert(pos, req);
        end
      end else if (shadow_slots.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.size   = shadow_slots[0].size;
        res.handle = shadow_slots[0].handle;
        res.name   = shadow_slots[0].name;
        void'(shadow_slots.pop_front());
      end
      res.occ = OccW'(shadow_slots.size());
      outcomes_due.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic [1:0] status, logic [SizeW-1:0] size,
                                logic [HandleW-1:0] handle, logic [NameW-1:0] name,
                                logic [OccW-1:0] occ);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        $error("result strobe with no outcome due: status %0d", status);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("out_size", 32'(want.size), 32'(size));
      compare_field("out_handle", 32'(want.handle), 32'(handle));
      compare_field("out_name", want.name, name);
      compare_field("occupancy", 32'(want.occ), 32'(occ));
    endfunction

    function bit idle();
      return outcomes_due.size() == 0;
    endfunction

    function void flush_leftovers();
      foreach (outcomes_due[i]) begin
        $error("outcome never arrived: status %0d occupancy %0d",
               outcomes_due[i].status, outcomes_due[i].occ);
        errors++;
      end
      outcomes_due.delete();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               command_i = CMD_INSERT;
  logic [SizeW-1:0]   file_size_i = '0;
  logic [HandleW-1:0] conn_handle_i = '0;
  logic [NameW-1:0]   name_ref_i = '0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [SizeW-1:0]   out_size_o;
  logic [HandleW-1:0] out_handle_o;
  logic [NameW-1:0]   out_name_o;
  logic [OccW-1:0]    occupancy_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_POLICY;
  logic [CfgW-1:0]    cfg_data_i = '0;

  queue_shadow shadow;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  request_queue_fifo_or_smallest_first #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .file_size_i   (file_size_i),
    .conn_handle_i (conn_handle_i),
    .name_ref_i    (name_ref_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_size_o    (out_size_o),
    .out_handle_o  (out_handle_o),
    .out_name_o    (out_name_o),
    .occupancy_o   (occupancy_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      shadow.check_outcome(status_o, out_size_o, out_handle_o, out_name_o, occupancy_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_request_queue_fifo_or_smallest_first: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves start high after the item is taken; the caller lowers it if it pauses.
  task automatic send_request(cmd_e cmd, logic [SizeW-1:0] size,
                              logic [HandleW-1:0] handle, logic [NameW-1:0] name);
    entry_t req;
    req.size   = size;
    req.handle = handle;
    req.name   = name;
    start         <= 1'b1;
    command_i     <= cmd;
    file_size_i   <= size;
    conn_handle_i <= handle;
    name_ref_i    <= name;
    do @(posedge clk_i); while (busy);
    shadow.note_request(cmd, req);
  endtask

  task automatic issue(cmd_e cmd, logic [SizeW-1:0] size,
                       logic [HandleW-1:0] handle, logic [NameW-1:0] name);
    int unsigned gap;
    send_request(cmd, size, handle, name);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 31) == 0) begin
        burst_left = $urandom_range(10, 40);
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops sending until every outcome has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (!shadow.idle());
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.note_reg_write(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Only bit 0 selects the policy; the upper bits carry noise.
  task automatic set_policy(bit smallest_first);
    logic [CfgW-2:0] noise;
    noise = (CfgW-1)'($urandom_range(0, 15));
    write_reg(REG_POLICY, {noise, smallest_first});
  endtask

  // Small sizes make ties common; wide ones exercise every bit of the key.
  function automatic logic [SizeW-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      return SizeW'($urandom_range(0, 15));
    end
    if (pick < 9) begin
      return SizeW'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? SizeMax : '0;
  endfunction

  initial begin
    cmd_e cmd;
    shadow = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_policy(1'b0);
    write_reg(REG_CAPACITY, 5'd16);
    issue(CMD_REMOVE, '0, '0, '0);
    issue(CMD_INSERT, SizeMax, '1, '1);
    issue(CMD_INSERT, '0, '0, '0);
    issue(CMD_INSERT, 31'd5, 16'h1234, 32'hA5A5_5A5A);

    // Switching to smallest-first with an unsorted queue held.
    drain();
    set_policy(1'b1);
    write_reg(REG_CAPACITY, 5'd4);
    issue(CMD_INSERT, 31'd1, 16'h0101, 32'h0000_0101);
    issue(CMD_INSERT, 31'd2, 16'h0202, 32'h0000_0202);

    // Capacity below the number of held requests.
    drain();
    write_reg(REG_CAPACITY, 5'd1);
    issue(CMD_INSERT, 31'd3, 16'h0303, 32'h0000_0303);
    issue(CMD_REMOVE, '0, '0, '0);

    drain();
    write_reg(REG_CAPACITY, 5'd0);
    issue(CMD_INSERT, 31'd4, 16'h0404, 32'h0000_0404);

    // Capacity above the depth is clamped.
    drain();
    write_reg(REG_CAPACITY, 5'd31);
    repeat (4) issue(CMD_REMOVE, SizeMax, '1, '1);
    issue(CMD_INSERT, 31'd9, 16'h0009, 32'h9000_0001);
    issue(CMD_INSERT, 31'd3, 16'h0003, 32'h3000_0001);
    issue(CMD_INSERT, 31'd9, 16'h0019, 32'h9000_0002);
    issue(CMD_INSERT, 31'd3, 16'h0013, 32'h3000_0002);
    issue(CMD_INSERT, SizeMax, 16'hFFFE, 32'hFFFF_FFFE);
    issue(CMD_INSERT, '0, 16'h0001, 32'h0000_0001);
    repeat (6) issue(CMD_REMOVE, '0, '0, '0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      set_policy(PhasePolicy[ph]);
      write_reg(REG_CAPACITY, CfgW'(PhaseCapacity[ph]));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        cmd = ($urandom_range(0, 99) < PhaseInsertPct[ph]) ? CMD_INSERT : CMD_REMOVE;
        issue(cmd, random_size(), 16'($urandom_range(0, 65535)), $urandom);
        if ($urandom_range(0, 127) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (3) @(posedge clk_i);
    shadow.flush_leftovers();
    if (shadow.errors == 0) begin
      $display("tb_request_queue_fifo_or_smallest_first: PASS");
    end else begin
      $display("tb_request_queue_fifo_or_smallest_first: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rqfs_pkg.sv
rtl/rqfs_cell.sv
rtl/request_queue_fifo_or_smallest_first.sv
test/tb_request_queue_fifo_or_smallest_first.sv
